### rtl/ierts_pkg.sv
// shared types, codes and field layout for the icmp echo rtt statistics block
// no dependencies; imported by every module of the block

package ierts_pkg;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_EXPECTED_ID   = 1'b0,
        REG_REPORT_OTHERS = 1'b1
    } cfg_reg_t;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;

    // packet verdict codes
    typedef enum logic [2:0] {
        V_NOT_ICMP  = 3'd0,
        V_SHORT_REQ = 3'd1,
        V_FOREIGN   = 3'd2,
        V_ACCEPTED  = 3'd3,
        V_REPORTED  = 3'd4,
        V_IGNORED   = 3'd5
    } verdict_t;

    localparam logic [7:0]  PROTO_ICMP        = 8'd1;
    localparam logic [7:0]  TYPE_ECHO_REPLY   = 8'd0;
    localparam logic [7:0]  TYPE_ECHO_REQUEST = 8'd8;
    localparam logic [15:0] MIN_ICMP_LEN      = 16'd8;
    localparam logic [15:0] MIN_REPLY_LEN     = 16'd16;

    localparam int IN_DATA_W  = 184;
    localparam int OUT_DATA_W = 320;

    localparam int SUM_W  = 48;
    localparam int CNT_W  = 32;
    localparam int RTT_W  = 32;
    localparam int STEP_W = $clog2(SUM_W);

    // queue between classifier and statistics engine
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one classified packet
    typedef struct packed {
        verdict_t    verdict;
        logic [15:0] icmp_length;
        logic [31:0] rtt_us;
        logic [15:0] seq;
        logic [7:0]  ttl;
        logic [15:0] type_and_code;
    } item_t;

    // statistics engine states
    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DEV
    } back_state_t;

endpackage

### rtl/icmp_echo_rtt_stats.sv
// top level of the icmp echo reply rtt statistics block: classifier, queue
// and statistics engine; depends on ierts_pkg and the three submodules
//
// channel   dir   word            accepted when
// --------  ----  --------------  --------------------------------
// s_*       in    packet fields   s_tvalid && s_tready
// m_*       out   verdict, stats  m_tvalid && m_tready
// cfg_*     in    register write  cfg_we high at a rising edge
//
// a non-reply packet or a rejected reply passes the queue and the output
// register from s to m; an accepted reply also passes the bit-serial running
// mean division (48-bit sum by 32-bit count), one quotient bit per cycle
// rst_n clears configuration, all statistics and both handshakes
// up to two classified packets wait in the queue while the engine divides or
// m_tready is low; s_tready drops only when that queue is full

module icmp_echo_rtt_stats import ierts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // packet input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // header_words, ip_protocol, packet_length, ip_ttl, msg_type, msg_code,
    // icmp_ident, seq_num, send_time_us, recv_time_us, 4 zero bits
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // result output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // verdict, icmp_length, rtt_us, seq_out, ttl_out, type_and_code,
    // reply_count, error_count, rtt_min_out, rtt_max_out, rtt_sum_out,
    // rtt_dev_sum_out, 5 zero bits
    output logic [OUT_DATA_W-1:0] m_tdata
);

    item_t classified;
    item_t head;
    logic  q_full;
    logic  q_not_empty;
    logic  q_pop;
    logic  q_push;

    // front side: unpack and classify in the accept cycle
    ierts_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_tdata),
        .item      (classified)
    );

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;

    // decouples the classifier from the slow statistics path
    ierts_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (classified),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (head)
    );

    // back side: statistics update and registered result word
    ierts_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_not_empty),
        .q_head    (head),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

### rtl/ierts_front.sv
// classifier: holds the configuration registers, unpacks the input word and
// derives verdict, icmp length and rtt; depends on ierts_pkg

module ierts_front import ierts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [IN_DATA_W-1:0]  in_data,
    output item_t                 item
);

    logic [15:0] expected_id_reg;
    logic        report_others_reg;

    logic [3:0]  header_words;
    logic [7:0]  ip_protocol;
    logic [15:0] packet_length;
    logic [7:0]  ip_ttl;
    logic [7:0]  msg_type;
    logic [7:0]  msg_code;
    logic [15:0] icmp_ident;
    logic [15:0] seq_num;
    logic [47:0] send_time_us;
    logic [47:0] recv_time_us;

    logic [15:0] hlen;
    logic [15:0] ilen;
    logic [48:0] diff;
    logic [31:0] rtt;
    verdict_t    verdict;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_id_reg   <= '0;
            report_others_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_EXPECTED_ID:   expected_id_reg   <= cfg_wdata;
                REG_REPORT_OTHERS: report_others_reg <= cfg_wdata[0];
            endcase
        end
    end

    assign header_words  = in_data[3:0];
    assign ip_protocol   = in_data[11:4];
    assign packet_length = in_data[27:12];
    assign ip_ttl        = in_data[35:28];
    assign msg_type      = in_data[43:36];
    assign msg_code      = in_data[51:44];
    assign icmp_ident    = in_data[67:52];
    assign seq_num       = in_data[83:68];
    assign send_time_us  = in_data[131:84];
    assign recv_time_us  = in_data[179:132];

    always_comb
    begin
        hlen = {10'd0, header_words, 2'b00};
        ilen = (packet_length > hlen) ? (packet_length - hlen) : 16'd0;
        diff = {1'b0, recv_time_us} - {1'b0, send_time_us};

        priority if (ip_protocol != PROTO_ICMP)
            verdict = V_NOT_ICMP;
        else if (ilen < MIN_ICMP_LEN || msg_type == TYPE_ECHO_REQUEST)
            verdict = V_SHORT_REQ;
        else if (msg_type == TYPE_ECHO_REPLY)
            verdict = (icmp_ident != expected_id_reg || ilen < MIN_REPLY_LEN)
                      ? V_FOREIGN : V_ACCEPTED;
        else if (report_others_reg)
            verdict = V_REPORTED;
        else
            verdict = V_IGNORED;

        // negative difference means receive before send
        priority if (diff[48] || verdict != V_ACCEPTED)
            rtt = '0;
        else if (diff[47:32] != 16'd0)
            rtt = '1;
        else
            rtt = diff[31:0];

        item.verdict       = verdict;
        item.icmp_length   = ilen;
        item.rtt_us        = rtt;
        item.seq           = seq_num;
        item.ttl           = ip_ttl;
        item.type_and_code = {msg_type, msg_code};
    end

endmodule

### rtl/ierts_queue.sv
// short fifo of classified packets between classifier and statistics engine
// depends on ierts_pkg

module ierts_queue import ierts_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  not_empty,
    output item_t head
);

    item_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !not_empty))
        else $error("queue read while empty");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

endmodule

### rtl/ierts_back.sv
// statistics engine: counters, min/max, saturating sums, bit-serial running
// mean division and the output register; depends on ierts_pkg

module ierts_back import ierts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  item_t                 q_head,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] out_data
);

    back_state_t         state_reg, state_next;
    item_t               item_reg, item_next;

    logic [CNT_W-1:0]    replies_reg, replies_next;
    logic [CNT_W-1:0]    errors_reg, errors_next;
    logic [RTT_W-1:0]    rtt_min_reg, rtt_min_next;
    logic [RTT_W-1:0]    rtt_max_reg, rtt_max_next;
    logic [SUM_W-1:0]    rtt_sum_reg, rtt_sum_next;
    logic [SUM_W-1:0]    dev_sum_reg, dev_sum_next;

    // divider: quotient shifts in where the dividend shifts out
    logic [SUM_W-1:0]    quot_reg, quot_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]    divisor_reg, divisor_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [CNT_W:0]      rem_shift;
    logic [CNT_W:0]      rem_trial;

    logic                out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic                out_free;
    logic [SUM_W:0]      sum_wide;
    logic [SUM_W-1:0]    rtt_ext;
    logic [SUM_W-1:0]    dev;
    logic [SUM_W:0]      dev_wide;

    function automatic logic [OUT_DATA_W-1:0] pack_result(
        input item_t            it,
        input logic [CNT_W-1:0] rep,
        input logic [CNT_W-1:0] err,
        input logic [RTT_W-1:0] mn,
        input logic [RTT_W-1:0] mx,
        input logic [SUM_W-1:0] sm,
        input logic [SUM_W-1:0] ds
    );
        return {5'd0, ds, sm, mx, mn, err, rep, it.type_and_code, it.ttl, it.seq,
                it.rtt_us, it.icmp_length, it.verdict};
    endfunction

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        replies_next   = replies_reg;
        errors_next    = errors_reg;
        rtt_min_next   = rtt_min_reg;
        rtt_max_next   = rtt_max_reg;
        rtt_sum_next   = rtt_sum_reg;
        dev_sum_next   = dev_sum_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        divisor_next   = divisor_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        q_pop          = 1'b0;

        rtt_ext   = {{(SUM_W-RTT_W){1'b0}}, q_head.rtt_us};
        sum_wide  = {1'b0, rtt_sum_reg} + {1'b0, rtt_ext};
        rem_shift = {rem_reg, quot_reg[SUM_W-1]};
        rem_trial = rem_shift - {1'b0, divisor_reg};
        dev       = '0;
        dev_wide  = '0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop     = 1'b1;
                    item_next = q_head;
                    if (q_head.verdict == V_ACCEPTED)
                    begin
                        replies_next = (replies_reg == '1) ? replies_reg : replies_reg + 1'b1;
                        if (q_head.rtt_us < rtt_min_reg || rtt_min_reg == '0)
                            rtt_min_next = q_head.rtt_us;
                        if (q_head.rtt_us > rtt_max_reg)
                            rtt_max_next = q_head.rtt_us;
                        rtt_sum_next = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
                        quot_next    = rtt_sum_next;
                        rem_next     = '0;
                        divisor_next = replies_next;
                        step_next    = STEP_W'(SUM_W - 1);
                        state_next   = S_DIV;
                    end
                    else
                    begin
                        if (q_head.verdict == V_REPORTED)
                            errors_next = (errors_reg == '1) ? errors_reg : errors_reg + 1'b1;
                        out_valid_next = 1'b1;
                        out_data_next  = pack_result(q_head, replies_next, errors_next,
                                                     rtt_min_next, rtt_max_next,
                                                     rtt_sum_next, dev_sum_next);
                    end
                end
            end

            S_DIV:
            begin
                // one restoring step per cycle
                if (!rem_trial[CNT_W])
                begin
                    rem_next  = rem_trial[CNT_W-1:0];
                    quot_next = {quot_reg[SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_shift[CNT_W-1:0];
                    quot_next = {quot_reg[SUM_W-2:0], 1'b0};
                end
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                    state_next = S_DEV;
            end

            S_DEV:
            begin
                if (out_free)
                begin
                    rtt_ext  = {{(SUM_W-RTT_W){1'b0}}, item_reg.rtt_us};
                    dev      = (quot_reg > rtt_ext) ? quot_reg - rtt_ext : rtt_ext - quot_reg;
                    dev_wide = {1'b0, dev_sum_reg} + {1'b0, dev};
                    dev_sum_next   = dev_wide[SUM_W] ? '1 : dev_wide[SUM_W-1:0];
                    out_valid_next = 1'b1;
                    out_data_next  = pack_result(item_reg, replies_reg, errors_reg,
                                                 rtt_min_reg, rtt_max_reg,
                                                 rtt_sum_reg, dev_sum_next);
                    state_next     = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            replies_reg   <= '0;
            errors_reg    <= '0;
            rtt_min_reg   <= '0;
            rtt_max_reg   <= '0;
            rtt_sum_reg   <= '0;
            dev_sum_reg   <= '0;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            replies_reg   <= replies_next;
            errors_reg    <= errors_next;
            rtt_min_reg   <= rtt_min_next;
            rtt_max_reg   <= rtt_max_next;
            rtt_sum_reg   <= rtt_sum_next;
            dev_sum_reg   <= dev_sum_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        quot_reg     <= quot_next;
        rem_reg      <= rem_next;
        divisor_reg  <= divisor_next;
        out_data_reg <= out_data_next;
    end

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> divisor_reg != '0)
        else $error("running mean divided by zero");

    a_replies_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> replies_reg >= $past(replies_reg))
        else $error("reply count went down");

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        rtt_min_reg <= rtt_max_reg)
        else $error("rtt minimum above maximum");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == S_IDLE && out_free)
        else $error("packet taken while engine busy");

endmodule

### tb/ierts_tb_pkg.sv
// word layouts of the packet and result streams of the icmp echo rtt statistics block
// depends on ierts_pkg for the verdict codes; shared by the checker and the test top

package ierts_tb_pkg;
    import ierts_pkg::*;

    // s_tdata, lowest field last
    typedef struct packed {
        logic [3:0]  pad;
        logic [47:0] recv_time_us;
        logic [47:0] send_time_us;
        logic [15:0] seq_num;
        logic [15:0] icmp_ident;
        logic [7:0]  msg_code;
        logic [7:0]  msg_type;
        logic [7:0]  ip_ttl;
        logic [15:0] packet_length;
        logic [7:0]  ip_protocol;
        logic [3:0]  header_words;
    } packet_word_t;

    // m_tdata, lowest field last
    typedef struct packed {
        logic [4:0]  pad;
        logic [47:0] rtt_dev_sum_out;
        logic [47:0] rtt_sum_out;
        logic [31:0] rtt_max_out;
        logic [31:0] rtt_min_out;
        logic [31:0] error_count;
        logic [31:0] reply_count;
        logic [15:0] type_and_code;
        logic [7:0]  ttl_out;
        logic [15:0] seq_out;
        logic [31:0] rtt_us;
        logic [15:0] icmp_length;
        verdict_t    verdict;
    } result_word_t;

endpackage

### tb/icmp_echo_rtt_stats_checker.sv
// watches the config, packet and result channels of icmp_echo_rtt_stats, predicts
// each result word and compares it; depends on ierts_pkg and ierts_tb_pkg

module icmp_echo_rtt_stats_checker
    import ierts_pkg::*;
    import ierts_tb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  end_of_run,
    output int                    pending,
    output int                    fail_count
);

    localparam longint unsigned SUM_MAX = 64'hFFFF_FFFF_FFFF;
    localparam longint unsigned RTT_MAX = 64'hFFFF_FFFF;

    // configuration copy
    logic [15:0] watched_id;
    logic        report_enable;

    // statistics copy
    logic [31:0] reply_total;
    logic [31:0] error_total;
    logic [31:0] min_rtt;
    logic [31:0] max_rtt;
    logic [47:0] rtt_total;
    logic [47:0] deviation_total;

    result_word_t predicted_results[$];
    result_word_t got_word;
    result_word_t want_word;
    int           bad_words;
    int           mismatch_total;

    function automatic result_word_t score_packet(packet_word_t p);
        result_word_t    r;
        longint unsigned hdr_bytes;
        longint unsigned ilen;
        longint unsigned diff;
        longint unsigned rtt;
        longint unsigned mean;
        longint unsigned dev;
        longint unsigned total;
        r = '0;
        rtt = 0;
        hdr_bytes = 64'(p.header_words) * 4;
        ilen = (64'(p.packet_length) > hdr_bytes) ? 64'(p.packet_length) - hdr_bytes : 0;
        if (p.ip_protocol != PROTO_ICMP)
            r.verdict = V_NOT_ICMP;
        else if (ilen < 64'(MIN_ICMP_LEN) || p.msg_type == TYPE_ECHO_REQUEST)
            r.verdict = V_SHORT_REQ;
        else if (p.msg_type == TYPE_ECHO_REPLY) begin
            if (p.icmp_ident != watched_id || ilen < 64'(MIN_REPLY_LEN))
                r.verdict = V_FOREIGN;
            else begin
                // receive before send counts as a zero round trip
                diff = (p.recv_time_us > p.send_time_us) ?
                       64'(p.recv_time_us) - 64'(p.send_time_us) : 0;
                rtt = (diff > RTT_MAX) ? RTT_MAX : diff;
                r.verdict = V_ACCEPTED;
                if (reply_total != '1)
                    reply_total = reply_total + 1;
                // a zero minimum means unset, so any sample replaces it
                if (rtt < 64'(min_rtt) || min_rtt == 0)
                    min_rtt = 32'(rtt);
                if (rtt > 64'(max_rtt))
                    max_rtt = 32'(rtt);
                total = 64'(rtt_total) + rtt;
                rtt_total = 48'((total > SUM_MAX) ? SUM_MAX : total);
                mean = 64'(rtt_total) / 64'(reply_total);
                dev = (mean > rtt) ? mean - rtt : rtt - mean;
                total = 64'(deviation_total) + dev;
                deviation_total = 48'((total > SUM_MAX) ? SUM_MAX : total);
            end
        end
        else if (report_enable) begin
            r.verdict = V_REPORTED;
            if (error_total != '1)
                error_total = error_total + 1;
        end
        else
            r.verdict = V_IGNORED;
        r.icmp_length     = 16'(ilen);
        r.rtt_us          = 32'(rtt);
        r.seq_out         = p.seq_num;
        r.ttl_out         = p.ip_ttl;
        r.type_and_code   = {p.msg_type, p.msg_code};
        r.reply_count     = reply_total;
        r.error_count     = error_total;
        r.rtt_min_out     = min_rtt;
        r.rtt_max_out     = max_rtt;
        r.rtt_sum_out     = rtt_total;
        r.rtt_dev_sum_out = deviation_total;
        return r;
    endfunction

    task automatic show_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
            $display("  %s: expected %0h, got %0h", name, want, got);
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            watched_id      = '0;
            report_enable   = 1'b0;
            reply_total     = '0;
            error_total     = '0;
            min_rtt         = '0;
            max_rtt         = '0;
            rtt_total       = '0;
            deviation_total = '0;
            bad_words       = 0;
            predicted_results.delete();
            pending        <= 0;
            mismatch_total <= 0;
        end
        else begin
            // results first, so a word never matches a packet taken at the same edge
            if (m_tvalid && m_tready) begin
                got_word = result_word_t'(m_tdata);
                if (predicted_results.size() == 0) begin
                    bad_words++;
                    if (bad_words <= 10)
                        $display("unexpected result word %h at %0t", m_tdata, $realtime);
                end
                else begin
                    want_word = predicted_results.pop_front();
                    if (got_word !== want_word) begin
                        bad_words++;
                        if (bad_words <= 10) begin
                            $display("result word mismatch at %0t", $realtime);
                            show_field("verdict", 64'(want_word.verdict),
                                       64'(got_word.verdict));
                            show_field("icmp_length", 64'(want_word.icmp_length),
                                       64'(got_word.icmp_length));
                            show_field("rtt_us", 64'(want_word.rtt_us),
                                       64'(got_word.rtt_us));
                            show_field("seq_out", 64'(want_word.seq_out),
                                       64'(got_word.seq_out));
                            show_field("ttl_out", 64'(want_word.ttl_out),
                                       64'(got_word.ttl_out));
                            show_field("type_and_code", 64'(want_word.type_and_code),
                                       64'(got_word.type_and_code));
                            show_field("reply_count", 64'(want_word.reply_count),
                                       64'(got_word.reply_count));
                            show_field("error_count", 64'(want_word.error_count),
                                       64'(got_word.error_count));
                            show_field("rtt_min_out", 64'(want_word.rtt_min_out),
                                       64'(got_word.rtt_min_out));
                            show_field("rtt_max_out", 64'(want_word.rtt_max_out),
                                       64'(got_word.rtt_max_out));
                            show_field("rtt_sum_out", 64'(want_word.rtt_sum_out),
                                       64'(got_word.rtt_sum_out));
                            show_field("rtt_dev_sum_out", 64'(want_word.rtt_dev_sum_out),
                                       64'(got_word.rtt_dev_sum_out));
                            show_field("pad", 64'(want_word.pad), 64'(got_word.pad));
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
                predicted_results.push_back(score_packet(packet_word_t'(s_tdata)));
            if (cfg_we) begin
                if (cfg_reg_t'(cfg_addr) == REG_EXPECTED_ID)
                    watched_id = cfg_wdata[15:0];
                else if (cfg_reg_t'(cfg_addr) == REG_REPORT_OTHERS)
                    report_enable = cfg_wdata[0];
            end
            pending        <= predicted_results.size();
            mismatch_total <= bad_words;
        end
    end

    always @(posedge end_of_run)
        if (pending != 0)
            $display("%0d result words never arrived", pending);

    // words still owed at the end count as failures
    assign fail_count = mismatch_total + (end_of_run ? pending : 0);

endmodule

### tb/icmp_echo_rtt_stats_test.sv
// test top for icmp_echo_rtt_stats: clock, reset, register writes, packet stimulus
// and result back-pressure; depends on ierts_pkg, ierts_tb_pkg and the checker

module icmp_echo_rtt_stats_test;
    import ierts_pkg::*;
    import ierts_tb_pkg::*;

    // run limit, well above the slowest legal run (bit-serial divides plus long gaps)
    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int PHASE_WORDS   = 425;
    localparam int LONG_HOLD     = 400;
    localparam int PRESSURE_BURST = 24;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    // header_words, ip_protocol, packet_length, ip_ttl, msg_type, msg_code,
    // icmp_ident, seq_num, send_time_us, recv_time_us, 4 zero bits
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    // verdict, icmp_length, rtt_us, seq_out, ttl_out, type_and_code, reply_count,
    // error_count, rtt_min_out, rtt_max_out, rtt_sum_out, rtt_dev_sum_out, 5 zero bits
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  end_of_run;
    int                    pending;
    int                    fail_count;
    int                    cycle_count;

    // quiet and long_hold_req are shared between the packet driver and the result receiver
    bit                    quiet;
    bit                    long_hold_req;
    logic [15:0]           current_id;

    icmp_echo_rtt_stats u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    icmp_echo_rtt_stats_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .end_of_run (end_of_run),
        .pending    (pending),
        .fail_count (fail_count)
    );

    initial
        clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("icmp_echo_rtt_stats regression: fail");
            $finish;
        end
    end

    // idle length: mostly none or short, now and then a long one
    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // ttl, code and sequence are random, the rest is given
    function automatic packet_word_t build_packet(logic [3:0] hw, logic [7:0] proto,
                                                  logic [15:0] plen, logic [7:0] kind,
                                                  logic [15:0] ident, logic [47:0] sent,
                                                  logic [47:0] received);
        packet_word_t p;
        p.pad           = '0;
        p.header_words  = hw;
        p.ip_protocol   = proto;
        p.packet_length = plen;
        p.ip_ttl        = 8'($urandom);
        p.msg_type      = kind;
        p.msg_code      = 8'($urandom);
        p.icmp_ident    = ident;
        p.seq_num       = 16'($urandom);
        p.send_time_us  = sent;
        p.recv_time_us  = received;
        return p;
    endfunction

    // mostly well-formed echo replies, some other icmp traffic, some raw noise
    function automatic packet_word_t random_packet();
        packet_word_t p;
        int           r;
        int           k;
        int           hw;
        int           ilen;
        r = $urandom_range(0, 99);
        p.pad           = '0;
        p.header_words  = 4'($urandom);
        p.ip_protocol   = 8'($urandom);
        p.packet_length = 16'($urandom);
        p.ip_ttl        = 8'($urandom);
        p.msg_type      = 8'($urandom);
        p.msg_code      = 8'($urandom);
        p.icmp_ident    = 16'($urandom);
        p.seq_num       = 16'($urandom);
        p.send_time_us  = 48'({$urandom, $urandom});
        p.recv_time_us  = 48'({$urandom, $urandom});
        if (r < 10)
            return p;
        p.ip_protocol = PROTO_ICMP;
        hw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 5;
        ilen = ($urandom_range(0, 99) < 85) ? $urandom_range(16, 1500) :
                                               $urandom_range(0, 20);
        p.packet_length = 16'(hw * 4 + ilen);
        p.header_words  = 4'(hw);
        if (r < 75)
        begin
            p.msg_type = TYPE_ECHO_REPLY;
            if ($urandom_range(0, 9) != 0)
                p.icmp_ident = current_id;
            k = $urandom_range(0, 99);
            if (k < 75)
                p.recv_time_us = p.send_time_us + 48'($urandom_range(0, 200000));
            else if (k < 83)
                p.recv_time_us = p.send_time_us - 48'($urandom_range(1, 5000));
            else if (k < 87)
                p.recv_time_us = p.send_time_us;
            else
                p.recv_time_us = p.send_time_us +
                                 48'({$urandom_range(0, 255), $urandom});
        end
        else if (r < 85)
            p.msg_type = TYPE_ECHO_REQUEST;
        return p;
    endfunction

    // offers one word after a random gap and holds it until taken
    task automatic send_packet(packet_word_t p);
        int gap;
        gap = quiet ? 0 : random_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // drop valid and let every predicted word come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        if (idx == REG_EXPECTED_ID)
            current_id = value;
    endtask

    // result receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int stall;
        int open;
        m_tready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall = LONG_HOLD;
            end
            else
                stall = quiet ? 0 : random_gap();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            open = $urandom_range(1, 8);
            repeat (open) @(posedge clk);
        end
    end

    // stimulus and verdict
    initial
    begin
        packet_word_t p;
        logic [15:0]  phase_id;
        bit           phase_report;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_addr      <= '0;
        cfg_wdata     <= '0;
        s_tvalid      <= 1'b0;
        s_tdata       <= '0;
        end_of_run    <= 1'b0;
        quiet         = 1'b0;
        long_hold_req = 1'b0;
        current_id    = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corner cases
        write_register(REG_EXPECTED_ID, 16'h1234);
        write_register(REG_REPORT_OTHERS, 16'd1);
        // not icmp: tcp, then every field at its top value
        send_packet(build_packet(4'd5, 8'd6, 16'd60, 8'd0, 16'h1234, 48'd0, 48'd10));
        p = '1;
        p.pad = '0;
        send_packet(p);
        // header longer than packet, then icmp part one short of a header
        send_packet(build_packet(4'd15, PROTO_ICMP, 16'd40, TYPE_ECHO_REPLY, 16'h1234,
                                 48'd0, 48'd5));
        send_packet(build_packet(4'd5, PROTO_ICMP, 16'd27, TYPE_ECHO_REPLY, 16'h1234,
                                 48'd0, 48'd5));
        send_packet(build_packet(4'd0, PROTO_ICMP, 16'd0, 8'd3, 16'h1234, 48'd0, 48'd5));
        // echo request
        send_packet(build_packet(4'd5, PROTO_ICMP, 16'd84, TYPE_ECHO_REQUEST, 16'h1234,
                                 48'd0, 48'd5));
        // reply with a foreign identifier, reply of 8 and of 15 bytes
        send_packet(build_packet(4'd5, PROTO_ICMP, 16'd84, TYPE_ECHO_REPLY, 16'h4321,
                                 48'd1000, 48'd1500));
        send_packet(build_packet(4'd5, PROTO_ICMP, 16'd28, TYPE_ECHO_REPLY, 16'h1234,
                                 48'd1000, 48'd1500));
        send_packet(build_packet(4'd5, PROTO_ICMP, 16'd35, TYPE_ECHO_REPLY, 16'h1234,
                                 48'd1000, 48'd1500));
        // accepted at exactly 16 bytes
        send_packet(build_packet(4'd5, PROTO_ICMP, 16'd36, TYPE_ECHO_REPLY, 16'h1234,
                                 48'd1000, 48'd1500));
        // zero round trip clears the minimum, the next sample sets it again
        send_packet(build_packet(4'd5, PROTO_ICMP, 16'd84, TYPE_ECHO_REPLY, 16'h1234,
                                 48'd7777, 48'd7777));
        send_packet(build_packet(4'd5, PROTO_ICMP, 16'd84, TYPE_ECHO_REPLY, 16'h1234,
                                 48'd100, 48'd400));
        // receive before send
        send_packet(build_packet(4'd5, PROTO_ICMP, 16'd84, TYPE_ECHO_REPLY, 16'h1234,
                                 48'd9000, 48'd8000));
        // round trip at, just above and far above 32 bits
        send_packet(build_packet(4'd5, PROTO_ICMP, 16'd84, TYPE_ECHO_REPLY, 16'h1234,
                                 48'd0, 48'hFFFF_FFFF));
        send_packet(build_packet(4'd5, PROTO_ICMP, 16'd84, TYPE_ECHO_REPLY, 16'h1234,
                                 48'd5, 48'h1_0000_0005));
        send_packet(build_packet(4'd5, PROTO_ICMP, 16'd84, TYPE_ECHO_REPLY, 16'h1234,
                                 48'd0, 48'hFFFF_FFFF_FFFF));
        // largest packet and timestamps
        send_packet(build_packet(4'd0, PROTO_ICMP, 16'hFFFF, TYPE_ECHO_REPLY, 16'h1234,
                                 48'hFFFF_FFFF_FFFE, 48'hFFFF_FFFF_FFFF));
        // other types reported
        send_packet(build_packet(4'd5, PROTO_ICMP, 16'd56, 8'd3, 16'h0, 48'd0, 48'd0));
        send_packet(build_packet(4'd5, PROTO_ICMP, 16'd56, 8'hFF, 16'hFFFF, 48'd0, 48'd0));
        wait_idle();
        // reporting off, identifier zero
        write_register(REG_REPORT_OTHERS, 16'd0);
        write_register(REG_EXPECTED_ID, 16'h0000);
        send_packet(build_packet(4'd5, PROTO_ICMP, 16'd56, 8'd11, 16'h0, 48'd0, 48'd0));
        send_packet(build_packet(4'd5, PROTO_ICMP, 16'd84, TYPE_ECHO_REPLY, 16'h0000,
                                 48'd50, 48'd2050));
        send_packet(build_packet(4'd5, PROTO_ICMP, 16'd84, TYPE_ECHO_REPLY, 16'h1234,
                                 48'd50, 48'd2050));

        // random phases, each under its own register setting
        for (int phase = 0; phase < 4; phase++)
        begin
            wait_idle();
            case (phase)
                0: begin phase_id = 16'($urandom); phase_report = 1'b1; end
                1: begin phase_id = 16'h0000;      phase_report = 1'b0; end
                2: begin phase_id = 16'hFFFF;      phase_report = 1'b1; end
                default: begin phase_id = 16'($urandom); phase_report = 1'($urandom); end
            endcase
            write_register(REG_EXPECTED_ID, phase_id);
            write_register(REG_REPORT_OTHERS, {15'd0, phase_report});
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                // a stretch with no idling on either side
                quiet = (phase == 1) && (n < 150);
                send_packet(random_packet());
                if (phase == 2 && n == 200)
                begin
                    // receiver holds off while back-to-back words fill the queue
                    quiet = 1'b1;
                    long_hold_req = 1'b1;
                    for (int b = 0; b < PRESSURE_BURST; b++)
                        send_packet(random_packet());
                    quiet = 1'b0;
                    // pause until every result is back
                    wait_idle();
                end
            end
        end
        quiet = 1'b0;

        wait_idle();
        repeat (60) @(posedge clk);
        end_of_run <= 1'b1;
        repeat (2) @(posedge clk);
        if (fail_count == 0)
            $display("icmp_echo_rtt_stats regression: pass");
        else
            $display("icmp_echo_rtt_stats regression: fail");
        $finish;
    end

endmodule
